@@ src/jsv_pkg.sv @@
package jsv_pkg;

  localparam int MaxNestingDef = 64;
  localparam int OffsetBitsDef = 32;
  localparam int QueueDepth = 2;

  typedef enum logic [4:0] {
    M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_OBJ_KEY, M_KEY_STR, M_KEY_ESC,
    M_COLON, M_VAL_STR, M_VAL_ESC, M_AFTER, M_LIT_TRUE, M_LIT_FALSE,
    M_LIT_NULL, M_NUM_SIGN, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_NUM_E,
    M_NUM_ESIGN, M_NUM_EXP
  } mode_t;

  typedef enum logic [3:0] {
    ST_VALID = 4'd0, ST_EMPTY = 4'd1, ST_UNEXPECTED = 4'd2, ST_UNTERM = 4'd3,
    ST_KEY = 4'd4, ST_COLON = 4'd5, ST_COMMA_BRACE = 4'd6,
    ST_COMMA_BRACKET = 4'd7, ST_BAD_BOOL = 4'd8, ST_BAD_NULL = 4'd9,
    ST_BAD_NUM = 4'd10, ST_BAD_EXP = 4'd11, ST_TRAILING = 4'd12,
    ST_TOO_DEEP = 4'd13
  } status_t;

  // byte class from the front end
  typedef enum logic [3:0] {
    C_OTHER, C_WS, C_QUOTE, C_LBRACE, C_RBRACE, C_LBRACK, C_RBRACK,
    C_COMMA, C_COLON, C_MINUS, C_DIGIT, C_DOT, C_EXP, C_PLUS, C_BSLASH
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    cls_t       cls;
    logic       eot;
  } req_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t k;
    k = C_OTHER;
    if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) k = C_WS;
    else if (c >= "0" && c <= "9") k = C_DIGIT;
    else begin
      case (c)
        "\"": k = C_QUOTE;
        "{": k = C_LBRACE;
        "}": k = C_RBRACE;
        "[": k = C_LBRACK;
        "]": k = C_RBRACK;
        ",": k = C_COMMA;
        ":": k = C_COLON;
        "-": k = C_MINUS;
        "+": k = C_PLUS;
        ".": k = C_DOT;
        "e", "E": k = C_EXP;
        8'h5c: k = C_BSLASH;
        default: k = C_OTHER;
      endcase
    end
    return k;
  endfunction

  // expected letter of a literal at a position
  function automatic logic [7:0] lit_char(input mode_t m, input logic [2:0] p);
    logic [7:0] r;
    r = 8'd0;
    if (m == M_LIT_TRUE) begin
      case (p)
        3'd1: r = "r";
        3'd2: r = "u";
        3'd3: r = "e";
        default: r = 8'd0;
      endcase
    end else if (m == M_LIT_FALSE) begin
      case (p)
        3'd1: r = "a";
        3'd2: r = "l";
        3'd3: r = "s";
        3'd4: r = "e";
        default: r = 8'd0;
      endcase
    end else begin
      case (p)
        3'd1: r = "u";
        3'd2: r = "l";
        3'd3: r = "l";
        default: r = 8'd0;
      endcase
    end
    return r;
  endfunction

endpackage

@@ src/json_syntax_validator_unit.sv @@
// channel | ports  | request fields (low bit up)
// in      | in_*   | tdata: data_byte[7:0]; tlast: end_of_text
// out     | out_*  | tdata: status[3:0], error_offset[35:4], zero pad
// one byte per cycle unless a result waits on a stalled output; a short
// queue splits classify and parse, the parse step against mode and stack
// top sets that rate. the end marker is held in the queue, and a result is
// valid in the cycle after the parse stage takes it; output stalls delay it.
// rst_n clears all control state; stack entries are written before read.
// an output stall backs up into the queue, then into in_tready.
module json_syntax_validator_unit #(
  parameter int MAX_NESTING = jsv_pkg::MaxNestingDef,
  parameter int OFFSET_BITS = jsv_pkg::OffsetBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status, error_offset, pad
);
  import jsv_pkg::*;

  logic q_valid, q_ready;
  req_t q_req;

  jsv_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .q_valid, .q_ready, .q_req
  );

  jsv_back #(.MAX_NESTING(MAX_NESTING), .OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_req, .out_tvalid, .out_tready, .out_tdata
  );
endmodule

@@ src/jsv_front.sv @@
module jsv_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  output logic            q_valid,
  input  logic            q_ready,
  output jsv_pkg::req_t   q_req
);
  import jsv_pkg::*;

  localparam int PW = $clog2(QueueDepth);

  req_t          mem_r [QueueDepth];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          push, pop;

  assign in_tready = (cnt_r != (PW+1)'(QueueDepth));
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != '0);
  assign pop = q_valid && q_ready;
  assign q_req = mem_r[rp_r];

  // classify and queue requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QueueDepth-1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == PW'(QueueDepth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= '{data: in_tdata, cls: classify(in_tdata), eot: in_tlast};
  end
endmodule

@@ src/jsv_back.sv @@
module jsv_back #(
  parameter int MAX_NESTING = jsv_pkg::MaxNestingDef,
  parameter int OFFSET_BITS = jsv_pkg::OffsetBitsDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  jsv_pkg::req_t q_req,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [39:0]   out_tdata
);
  import jsv_pkg::*;

  localparam int LW = $clog2(MAX_NESTING + 1);
  localparam logic [OFFSET_BITS-1:0] OfsMax = '1;

  mode_t                  mode_r, mode_nxt;
  logic [MAX_NESTING-1:0] kind_r;
  logic [LW-1:0]          lvl_r, lvl_nxt;
  logic [OFFSET_BITS-1:0] ofs_r, lstart_r, lstart_nxt, lofs_r, lofs_nxt;
  logic [2:0]             prog_r, prog_nxt;
  status_t                lst_r, lst_nxt;
  logic                   push_k, push_kv, pop_k;
  logic                   top_kind;
  logic                   take;
  logic                   ov_r;
  logic [3:0]             ost_r;
  logic [31:0]            oofs_r;
  status_t                fst;
  logic [OFFSET_BITS-1:0] fofs;
  logic [63:0]            fofs_w;

  assign q_ready = !ov_r || out_tready;
  assign take = q_valid && q_ready;
  assign out_tvalid = ov_r;
  assign out_tdata = {4'd0, oofs_r, ost_r};

  // stack top sits at bit 0 of the kind shift register
  assign top_kind = (lvl_r != '0) ? kind_r[0] : 1'b0;
  assign pop_k = (lvl_nxt != lvl_r) && !push_k;

  // per-byte parse step
  always_comb begin
    logic [7:0] c;
    cls_t k;
    logic ws, av;
    logic [2:0] len;
    c = q_req.data;
    k = q_req.cls;
    ws = (k == C_WS);
    av = 1'b0;
    mode_nxt = mode_r;
    lvl_nxt = lvl_r;
    prog_nxt = prog_r;
    lstart_nxt = lstart_r;
    lst_nxt = lst_r;
    lofs_nxt = lofs_r;
    push_k = 1'b0;
    push_kv = 1'b0;
    len = (mode_r == M_LIT_FALSE) ? 3'd5 : 3'd4;
    unique case (mode_r)
      M_VALUE, M_ARR_FIRST: begin
        if (!ws) begin
          if (mode_r == M_ARR_FIRST && k == C_RBRACK) begin
            lvl_nxt = lvl_r - 1'b1;
            mode_nxt = M_AFTER;
          end else begin
            mode_nxt = M_VALUE;
            case (k)
              C_QUOTE: mode_nxt = M_VAL_STR;
              C_LBRACE, C_LBRACK: begin
                if (lvl_r >= LW'(MAX_NESTING)) begin
                  lst_nxt = ST_TOO_DEEP;
                  lofs_nxt = ofs_r;
                end else begin
                  push_k = 1'b1;
                  push_kv = (k == C_LBRACK);
                  lvl_nxt = lvl_r + 1'b1;
                  mode_nxt = (k == C_LBRACK) ? M_ARR_FIRST : M_OBJ_FIRST;
                end
              end
              C_MINUS: mode_nxt = M_NUM_SIGN;
              C_DIGIT: mode_nxt = M_NUM_INT;
              default: begin
                if (c == "t" || c == "f" || c == "n") begin
                  mode_nxt = (c == "t") ? M_LIT_TRUE : (c == "f") ? M_LIT_FALSE : M_LIT_NULL;
                  prog_nxt = 3'd1;
                  lstart_nxt = ofs_r;
                end else begin
                  lst_nxt = ST_UNEXPECTED;
                  lofs_nxt = ofs_r;
                end
              end
            endcase
          end
        end
      end
      M_OBJ_FIRST, M_OBJ_KEY: begin
        if (!ws) begin
          if (k == C_RBRACE && mode_r == M_OBJ_FIRST) begin
            lvl_nxt = lvl_r - 1'b1;
            mode_nxt = M_AFTER;
          end else if (k == C_QUOTE) mode_nxt = M_KEY_STR;
          else begin
            lst_nxt = ST_KEY;
            lofs_nxt = ofs_r;
          end
        end
      end
      M_KEY_STR: begin
        if (k == C_QUOTE) mode_nxt = M_COLON;
        else if (k == C_BSLASH) mode_nxt = M_KEY_ESC;
      end
      M_KEY_ESC: mode_nxt = M_KEY_STR;
      M_COLON: begin
        if (!ws) begin
          if (k == C_COLON) mode_nxt = M_VALUE;
          else begin
            lst_nxt = ST_COLON;
            lofs_nxt = ofs_r;
          end
        end
      end
      M_VAL_STR: begin
        if (k == C_QUOTE) mode_nxt = M_AFTER;
        else if (k == C_BSLASH) mode_nxt = M_VAL_ESC;
      end
      M_VAL_ESC: mode_nxt = M_VAL_STR;
      M_LIT_TRUE, M_LIT_FALSE, M_LIT_NULL: begin
        if (prog_r < len && c == lit_char(mode_r, prog_r)) begin
          prog_nxt = prog_r + 1'b1;
          if (prog_nxt == len) mode_nxt = M_AFTER;
        end else begin
          lst_nxt = (mode_r == M_LIT_NULL) ? ST_BAD_NULL : ST_BAD_BOOL;
          lofs_nxt = lstart_r;
        end
      end
      M_NUM_SIGN, M_NUM_DOT: begin
        if (k == C_DIGIT) mode_nxt = (mode_r == M_NUM_SIGN) ? M_NUM_INT : M_NUM_FRAC;
        else begin
          lst_nxt = ST_BAD_NUM;
          lofs_nxt = ofs_r;
        end
      end
      M_NUM_INT: begin
        if (k == C_DOT) mode_nxt = M_NUM_DOT;
        else if (k == C_EXP) mode_nxt = M_NUM_E;
        else if (k != C_DIGIT) av = 1'b1;
      end
      M_NUM_FRAC: begin
        if (k == C_EXP) mode_nxt = M_NUM_E;
        else if (k != C_DIGIT) av = 1'b1;
      end
      M_NUM_E: begin
        if (k == C_PLUS || k == C_MINUS) mode_nxt = M_NUM_ESIGN;
        else if (k == C_DIGIT) mode_nxt = M_NUM_EXP;
        else begin
          lst_nxt = ST_BAD_EXP;
          lofs_nxt = ofs_r;
        end
      end
      M_NUM_ESIGN: begin
        if (k == C_DIGIT) mode_nxt = M_NUM_EXP;
        else begin
          lst_nxt = ST_BAD_EXP;
          lofs_nxt = ofs_r;
        end
      end
      M_NUM_EXP: if (k != C_DIGIT) av = 1'b1;
      default: av = 1'b1;
    endcase
    // separator or close after a value
    if (av) begin
      mode_nxt = M_AFTER;
      if (!ws) begin
        if (lvl_r == '0) begin
          lst_nxt = ST_TRAILING;
          lofs_nxt = ofs_r;
        end else if (!top_kind) begin
          if (k == C_RBRACE) lvl_nxt = lvl_r - 1'b1;
          else if (k == C_COMMA) mode_nxt = M_OBJ_KEY;
          else begin
            lst_nxt = ST_COMMA_BRACE;
            lofs_nxt = ofs_r;
          end
        end else begin
          if (k == C_RBRACK) lvl_nxt = lvl_r - 1'b1;
          else if (k == C_COMMA) mode_nxt = M_VALUE;
          else begin
            lst_nxt = ST_COMMA_BRACKET;
            lofs_nxt = ofs_r;
          end
        end
      end
    end
  end

  // end-of-text verdict
  always_comb begin
    fofs = ofs_r;
    fst = ST_VALID;
    if (lst_r != ST_VALID) begin
      fst = lst_r;
      fofs = lofs_r;
    end else begin
      unique case (mode_r)
        M_VALUE: fst = (lvl_r == '0) ? ST_EMPTY : ST_UNEXPECTED;
        M_ARR_FIRST: fst = ST_UNEXPECTED;
        M_OBJ_FIRST, M_OBJ_KEY: fst = ST_KEY;
        M_KEY_STR, M_KEY_ESC, M_VAL_STR, M_VAL_ESC: fst = ST_UNTERM;
        M_COLON: fst = ST_COLON;
        M_LIT_TRUE, M_LIT_FALSE: begin
          fst = ST_BAD_BOOL;
          fofs = lstart_r;
        end
        M_LIT_NULL: begin
          fst = ST_BAD_NULL;
          fofs = lstart_r;
        end
        M_NUM_SIGN, M_NUM_DOT: fst = ST_BAD_NUM;
        M_NUM_E, M_NUM_ESIGN: fst = ST_BAD_EXP;
        default: fst = (lvl_r == '0) ? ST_VALID :
                       (top_kind ? ST_COMMA_BRACKET : ST_COMMA_BRACE);
      endcase
    end
    fofs_w = 64'(fofs);
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_VALUE;
      lvl_r <= '0;
      ofs_r <= '0;
      prog_r <= '0;
      lstart_r <= '0;
      lst_r <= ST_VALID;
      lofs_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (take && q_req.eot) ov_r <= 1'b1;
      else if (out_tvalid && out_tready) ov_r <= 1'b0;
      if (take) begin
        if (q_req.eot) begin
          ost_r <= fst;
          oofs_r <= fofs_w[31:0];
          mode_r <= M_VALUE;
          lvl_r <= '0;
          ofs_r <= '0;
          prog_r <= '0;
          lstart_r <= '0;
          lst_r <= ST_VALID;
          lofs_r <= '0;
        end else begin
          if (lst_r == ST_VALID) begin
            mode_r <= mode_nxt;
            lvl_r <= lvl_nxt;
            prog_r <= prog_nxt;
            lstart_r <= lstart_nxt;
            lst_r <= lst_nxt;
            lofs_r <= lofs_nxt;
          end
          if (ofs_r != OfsMax) ofs_r <= ofs_r + 1'b1;
        end
      end
    end
  end

  // container kind stack, shifts in on open and out on close
  always_ff @(posedge clk) begin
    if (take && !q_req.eot && lst_r == ST_VALID) begin
      if (push_k) kind_r <= (kind_r << 1) | MAX_NESTING'(push_kv);
      else if (pop_k) kind_r <= kind_r >> 1;
    end
  end
endmodule

@@ tb/sv/tb_json_syntax_validator_unit.sv @@
module tb_json_syntax_validator_unit;
  import jsv_pkg::*;

  localparam int NestLimit = 64;
  localparam int IdleLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // data_byte
  logic        in_tlast;   // end_of_text
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // status[3:0], error_offset[35:4], zero pad

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } text_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
  } verdict_t;

  text_req_t pending_q[$];
  verdict_t  verdict_q[$];

  // parser shadow state
  mode_t       sh_mode;
  logic        sh_kind[NestLimit];
  int unsigned sh_level;
  logic [31:0] sh_offset;
  int unsigned sh_progress;
  logic [31:0] sh_lit_start;
  status_t     sh_status;
  logic [31:0] sh_err_offset;

  int  mismatches;
  int  idle_cycles;
  bit  timed_out;
  bit  hold_for_drain;
  int  burst_left;
  int  gap_left;
  int  stall_phase;
  int  stall_period;

  json_syntax_validator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] word_letter(mode_t m, int unsigned p);
    string w;
    if (m == M_LIT_TRUE) w = "true";
    else if (m == M_LIT_FALSE) w = "false";
    else w = "null";
    return (p < w.len()) ? w[p] : 8'd0;
  endfunction

  task automatic shadow_clear();
    sh_mode = M_VALUE;
    sh_level = 0;
    sh_offset = '0;
    sh_progress = 0;
    sh_lit_start = '0;
    sh_status = ST_VALID;
    sh_err_offset = '0;
  endtask

  task automatic flag(status_t s, logic [31:0] o);
    sh_status = s;
    sh_err_offset = o;
  endtask

  task automatic open_nest(logic k, logic [31:0] o);
    if (sh_level >= NestLimit) begin
      flag(ST_TOO_DEEP, o);
    end else begin
      sh_kind[sh_level] = k;
      sh_level++;
      sh_mode = k ? M_ARR_FIRST : M_OBJ_FIRST;
    end
  endtask

  task automatic start_value(logic [7:0] c, logic [31:0] o);
    if (is_space(c)) return;
    case (c)
      "\"": sh_mode = M_VAL_STR;
      "{": open_nest(1'b0, o);
      "[": open_nest(1'b1, o);
      "t": begin sh_mode = M_LIT_TRUE; sh_progress = 1; sh_lit_start = o; end
      "f": begin sh_mode = M_LIT_FALSE; sh_progress = 1; sh_lit_start = o; end
      "n": begin sh_mode = M_LIT_NULL; sh_progress = 1; sh_lit_start = o; end
      "-": sh_mode = M_NUM_SIGN;
      default: begin
        if (is_num(c)) sh_mode = M_NUM_INT;
        else flag(ST_UNEXPECTED, o);
      end
    endcase
  endtask

  task automatic close_value(logic [7:0] c, logic [31:0] o);
    sh_mode = M_AFTER;
    if (is_space(c)) return;
    if (sh_level == 0) begin
      flag(ST_TRAILING, o);
    end else if (!sh_kind[sh_level-1]) begin
      if (c == "}") sh_level--;
      else if (c == ",") sh_mode = M_OBJ_KEY;
      else flag(ST_COMMA_BRACE, o);
    end else begin
      if (c == "]") sh_level--;
      else if (c == ",") sh_mode = M_VALUE;
      else flag(ST_COMMA_BRACKET, o);
    end
  endtask

  // one text byte through the parser shadow
  task automatic parse_byte(logic [7:0] c, logic [31:0] o);
    int unsigned wlen;
    case (sh_mode)
      M_VALUE: start_value(c, o);
      M_ARR_FIRST: begin
        if (!is_space(c)) begin
          if (c == "]") begin sh_level--; sh_mode = M_AFTER; end
          else begin sh_mode = M_VALUE; start_value(c, o); end
        end
      end
      M_OBJ_FIRST, M_OBJ_KEY: begin
        if (!is_space(c)) begin
          if (c == "}" && sh_mode == M_OBJ_FIRST) begin
            sh_level--;
            sh_mode = M_AFTER;
          end else if (c == "\"") sh_mode = M_KEY_STR;
          else flag(ST_KEY, o);
        end
      end
      M_KEY_STR: begin
        if (c == "\"") sh_mode = M_COLON;
        else if (c == 8'h5c) sh_mode = M_KEY_ESC;
      end
      M_KEY_ESC: sh_mode = M_KEY_STR;
      M_COLON: begin
        if (!is_space(c)) begin
          if (c == ":") sh_mode = M_VALUE;
          else flag(ST_COLON, o);
        end
      end
      M_VAL_STR: begin
        if (c == "\"") sh_mode = M_AFTER;
        else if (c == 8'h5c) sh_mode = M_VAL_ESC;
      end
      M_VAL_ESC: sh_mode = M_VAL_STR;
      M_LIT_TRUE, M_LIT_FALSE, M_LIT_NULL: begin
        wlen = (sh_mode == M_LIT_FALSE) ? 5 : 4;
        if (sh_progress < wlen && c == word_letter(sh_mode, sh_progress)) begin
          sh_progress++;
          if (sh_progress == wlen) sh_mode = M_AFTER;
        end else begin
          flag((sh_mode == M_LIT_NULL) ? ST_BAD_NULL : ST_BAD_BOOL, sh_lit_start);
        end
      end
      M_NUM_SIGN, M_NUM_DOT: begin
        if (is_num(c)) sh_mode = (sh_mode == M_NUM_SIGN) ? M_NUM_INT : M_NUM_FRAC;
        else flag(ST_BAD_NUM, o);
      end
      M_NUM_INT: begin
        if (!is_num(c)) begin
          if (c == ".") sh_mode = M_NUM_DOT;
          else if (c == "e" || c == "E") sh_mode = M_NUM_E;
          else close_value(c, o);
        end
      end
      M_NUM_FRAC: begin
        if (!is_num(c)) begin
          if (c == "e" || c == "E") sh_mode = M_NUM_E;
          else close_value(c, o);
        end
      end
      M_NUM_E: begin
        if (c == "+" || c == "-") sh_mode = M_NUM_ESIGN;
        else if (is_num(c)) sh_mode = M_NUM_EXP;
        else flag(ST_BAD_EXP, o);
      end
      M_NUM_ESIGN: begin
        if (is_num(c)) sh_mode = M_NUM_EXP;
        else flag(ST_BAD_EXP, o);
      end
      M_NUM_EXP: if (!is_num(c)) close_value(c, o);
      default: close_value(c, o);
    endcase
  endtask

  // verdict at the end marker
  function automatic verdict_t end_verdict();
    verdict_t v;
    v.offset = sh_offset;
    if (sh_status != ST_VALID) begin
      v.status = sh_status;
      v.offset = sh_err_offset;
      return v;
    end
    case (sh_mode)
      M_VALUE: v.status = (sh_level == 0) ? ST_EMPTY : ST_UNEXPECTED;
      M_ARR_FIRST: v.status = ST_UNEXPECTED;
      M_OBJ_FIRST, M_OBJ_KEY: v.status = ST_KEY;
      M_KEY_STR, M_KEY_ESC, M_VAL_STR, M_VAL_ESC: v.status = ST_UNTERM;
      M_COLON: v.status = ST_COLON;
      M_LIT_TRUE, M_LIT_FALSE: begin v.status = ST_BAD_BOOL; v.offset = sh_lit_start; end
      M_LIT_NULL: begin v.status = ST_BAD_NULL; v.offset = sh_lit_start; end
      M_NUM_SIGN, M_NUM_DOT: v.status = ST_BAD_NUM;
      M_NUM_E, M_NUM_ESIGN: v.status = ST_BAD_EXP;
      default: begin
        if (sh_level == 0) v.status = ST_VALID;
        else v.status = sh_kind[sh_level-1] ? ST_COMMA_BRACKET : ST_COMMA_BRACE;
      end
    endcase
    return v;
  endfunction

  task automatic predict(text_req_t r);
    if (r.eot) begin
      verdict_q.insert(verdict_q.size(), end_verdict());
      shadow_clear();
    end else begin
      if (sh_status == ST_VALID) parse_byte(r.data, sh_offset);
      if (sh_offset != 32'hffff_ffff) sh_offset++;
    end
  endtask

  // text builders
  task automatic put_text(string s);
    text_req_t r;
    for (int i = 0; i < s.len(); i++) begin
      r.data = s[i];
      r.eot = 1'b0;
      pending_q.insert(pending_q.size(), r);
    end
  endtask

  task automatic put_end();
    text_req_t r;
    r.data = 8'($urandom);
    r.eot = 1'b1;
    pending_q.insert(pending_q.size(), r);
  endtask

  function automatic string rand_atom();
    string s;
    case ($urandom_range(0, 9))
      0: s = "true";
      1: s = "false";
      2: s = "null";
      3: s = $sformatf("%0d", $urandom_range(0, 999));
      4: s = $sformatf("-%0d.%0de%0d", $urandom_range(0, 9), $urandom_range(0, 99),
                       $urandom_range(0, 9));
      5: s = $sformatf("%0dE-%0d", $urandom_range(0, 99), $urandom_range(0, 9));
      6: s = "\"a\\\"b\"";
      default: s = "\"x y\"";
    endcase
    return s;
  endfunction

  function automatic string rand_value(int depth);
    string s;
    int n;
    if (depth <= 0 || $urandom_range(0, 2) == 0) return rand_atom();
    n = $urandom_range(0, 3);
    if ($urandom_range(0, 1)) begin
      s = "[";
      for (int i = 0; i < n; i++) begin
        if (i > 0) s = {s, ", "};
        s = {s, rand_value(depth - 1)};
      end
      s = {s, "]"};
    end else begin
      s = "{";
      for (int i = 0; i < n; i++) begin
        if (i > 0) s = {s, ","};
        s = {s, "\"k\\\\\" :", rand_value(depth - 1)};
      end
      s = {s, " }"};
    end
    return s;
  endfunction

  task automatic put_random_text();
    string s;
    text_req_t r;
    int pos;
    s = rand_value($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) s = {" \t", s, "\n"};
    // break some texts: cut, corrupt one byte, or append noise
    case ($urandom_range(0, 9))
      0: if (s.len() > 1) s = s.substr(0, $urandom_range(0, s.len() - 2));
      1, 2: begin
        pos = $urandom_range(0, s.len() - 1);
        s[pos] = 8'($urandom);
      end
      3: s = {s, "x"};
      default: ;
    endcase
    put_text(s);
    put_end();
    // occasional all-random bytes text
    if ($urandom_range(0, 7) == 0) begin
      for (int i = 0; i < $urandom_range(1, 6); i++) begin
        r.data = 8'($urandom);
        r.eot = 1'b0;
        pending_q.insert(pending_q.size(), r);
      end
      put_end();
    end
  endtask

  // sender with bursts and gaps
  always @(posedge clk) begin
    text_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) predict(pending_q.pop_front());
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          in_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0 && !hold_for_drain) begin
          nxt = pending_q[0];
          in_tvalid <= 1'b1;
          in_tdata <= nxt.data;
          in_tlast <= nxt.eot;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern and result check
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_phase <= 0;
      stall_period <= 7;
      idle_cycles <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[3:0] !== want.status || out_tdata[35:4] !== want.offset ||
              out_tdata[39:36] !== 4'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want status %0d offset %0d, got status %0d offset %0d",
                       want.status, want.offset, out_tdata[3:0], out_tdata[35:4]);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      stall_phase <= (stall_phase + 1) % stall_period;
      if (stall_phase == stall_period - 1 && $urandom_range(0, 3) == 0)
        stall_period <= $urandom_range(2, 13);
      // long ready stretches mixed with a rotating stall pattern
      out_tready <= (stall_period > 10) ? 1'b1 : (stall_phase % 3 != 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n && idle_cycles >= IdleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("json_syntax_validator_unit verification failed");
      $finish;
    end
  end

  initial begin
    string deep;
    mismatches = 0;
    timed_out = 1'b0;
    hold_for_drain = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    shadow_clear();

    // directed texts: one per special case
    put_end();                                   // empty
    put_text("{\"a\":[1,2.5e+3,-0.1E9,true,false,null,\"s\\\"\"]}"); put_end();
    put_text("tru"); put_end();                  // literal cut by the end
    put_text("[nulx]"); put_end();               // bad null at its start
    put_text("truex"); put_end();                // letter after literal
    put_text("\"ab\\"); put_end();               // ends after backslash
    put_text("{1}"); put_end();
    put_text("{\"k\" 1}"); put_end();
    put_text("{\"k\":1 2}"); put_end();
    put_text("[1 2]"); put_end();
    put_text("-x"); put_end();
    put_text("1e+"); put_end();
    put_text("1 2"); put_end();
    put_text("[,]"); put_end();
    put_text("{\"a\":1,"); put_end();
    put_text({8'hff, 8'h00, 8'h7f}); put_end();
    deep = "";
    for (int i = 0; i < NestLimit; i++) deep = {deep, "["};
    for (int i = 0; i < NestLimit; i++) deep = {deep, "]"};
    put_text(deep); put_end();                   // exactly at the limit
    put_text({deep.substr(0, NestLimit - 1), "{"}); put_end();  // one past

    while (pending_q.size() < 1800) put_random_text();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // pause once until everything has drained
    wait (pending_q.size() < 900);
    hold_for_drain = 1'b1;
    wait (verdict_q.size() == 0 && !in_tvalid);
    repeat (5) @(posedge clk);
    hold_for_drain = 1'b0;

    wait (pending_q.size() == 0 && !in_tvalid);
    wait (verdict_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0)
      $display("json_syntax_validator_unit verification clean");
    else
      $display("json_syntax_validator_unit verification failed");
    $finish;
  end

endmodule
